// ----- rtl/pn3d_pkg.sv -----
// ---------------------------------------------------------------------------
// pn3d_pkg
// Shared types, constants and a helper function for the 3D noise core.
// ---------------------------------------------------------------------------
package pn3d_pkg;

	localparam int TABLE_DEPTH = 512;
	localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
	localparam int FRAC_BITS   = 16;
	localparam int COORD_W     = 32;
	localparam int OUT_W       = 18;
	localparam int OUT_FRAC    = 16;

	// fraction and corner offset widths
	localparam int FR_W  = FRAC_BITS;
	localparam int OFS_W = FRAC_BITS + 2;   // signed, covers [-one, one)
	localparam int GR_W  = FRAC_BITS + 3;   // signed, sum of two offsets
	localparam int FD_W  = FRAC_BITS + 1;   // fade in [0, one]
	localparam int LP_W  = FRAC_BITS + 4;   // lerp results stay within gradient range

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_EVAL = 1'b1;

	localparam int IN_DATA_W  = 1 + TABLE_AW + 8 + 3 * COORD_W;
	localparam int IN_TDATA_W = ((IN_DATA_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

	typedef logic signed [OFS_W-1:0] ofs_t;
	typedef logic signed [GR_W-1:0]  grad_t;
	typedef logic signed [LP_W-1:0]  lval_t;

	// Gradient pick from hash bits h[3:0]; one of the cube-edge directions (x+-y, x+-z, y+-z).
	function automatic grad_t grad_sel(input logic [3:0] h, input ofs_t x, input ofs_t y,
		input ofs_t z);
		grad_t u;
		grad_t v;
		u = (h < 4'd8) ? grad_t'(x) : grad_t'(y);
		if (h < 4'd4)
			v = grad_t'(y);
		else if (h == 4'd12 || h == 4'd14)
			v = grad_t'(x);
		else
			v = grad_t'(z);
		if (h[0]) u = -u;
		if (h[1]) v = -v;
		return u + v;
	endfunction

endpackage

// ----- rtl/perlin_noise_3d_core.sv -----
// ---------------------------------------------------------------------------
// perlin_noise_3d_core
// 3D improved gradient noise, one point per clock unless the pipe is stalled.
// ---------------------------------------------------------------------------
// Fully pipelined: one transaction per cycle while the output side is ready and
// no load is held off; each result leaves through the output register. The hash
// table lives in fourteen 512x8 copies (one per concurrent read port, all
// written together by load transactions); reads at each hash level take one
// registered memory stage. The whole pipe advances together and stalls when the
// output register is full and not taken. A load transaction is also held off
// while an evaluation in stages s1..s4 still has table reads pending, so every
// evaluation sees the table as it was when accepted.
// The table must be fully loaded before the first evaluation; a load
// transaction returns noise zero with was_load set.
module perlin_noise_3d_core import pn3d_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// mode, table_index, table_value, coord_x, coord_y, coord_z (low bit up)
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// noise_value (low bits), zero fill
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// was_load
	output logic                   m_tuser
);
	localparam int NST = 12;
	localparam int NRD = 14;

	logic                 en;
	logic [NST:1]         vld;
	logic [NST:1]         ld;
	logic                 accept;
	logic                 eval_busy;
	logic                 load_hold;

	logic                 mode;
	logic [TABLE_AW-1:0]  tix;
	logic [7:0]           tval;
	logic [COORD_W-1:0]   cx, cy, cz;

	assign mode = s_tdata[0];
	assign tix  = s_tdata[TABLE_AW:1];
	assign tval = s_tdata[TABLE_AW+8:TABLE_AW+1];
	assign cx   = s_tdata[TABLE_AW+9 +: COORD_W];
	assign cy   = s_tdata[TABLE_AW+9+COORD_W +: COORD_W];
	assign cz   = s_tdata[TABLE_AW+9+2*COORD_W +: COORD_W];

	// evaluations in s1..s4 still read the table on later edges
	assign eval_busy = |(vld[4:1] & ~ld[4:1]);
	assign load_hold = s_tvalid && (mode == MODE_LOAD) && eval_busy;

	assign en       = !vld[NST] || m_tready;
	assign s_tready = en && !load_hold;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = vld[NST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else if (en) begin
			vld <= {vld[NST-1:1], accept};
		end
	end

	// ---- per-stage side data ----
	logic [FR_W-1:0]     fx_s [1:6];
	logic [FR_W-1:0]     fy_s [1:6];
	logic [FR_W-1:0]     fz_s [1:6];
	logic [7:0]          ix_s1, iy_s1, iz_s1;
	logic [7:0]          iy_s2, iz_s2, iz_s3, iz_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			ld    <= {ld[NST-1:1], accept && (mode == MODE_LOAD)};
			fx_s[1] <= cx[FR_W-1:0];
			fy_s[1] <= cy[FR_W-1:0];
			fz_s[1] <= cz[FR_W-1:0];
			for (int i = 2; i <= 6; i++) begin
				fx_s[i] <= fx_s[i-1];
				fy_s[i] <= fy_s[i-1];
				fz_s[i] <= fz_s[i-1];
			end
			ix_s1 <= cx[FRAC_BITS +: 8];
			iy_s1 <= cy[FRAC_BITS +: 8];
			iz_s1 <= cz[FRAC_BITS +: 8];
			iy_s2 <= iy_s1;
			iz_s2 <= iz_s1;
			iz_s3 <= iz_s2;
			iz_s4 <= iz_s3;
		end
	end

	// ---- hash table copies: write on load, registered reads ----
	logic                 we;
	logic [7:0]           mem [NRD][TABLE_DEPTH];
	logic [TABLE_AW-1:0]  ra [NRD];
	logic [7:0]           rd [NRD];

	assign we = accept && (mode == MODE_LOAD);

	always_ff @(posedge clk) begin
		for (int k = 0; k < NRD; k++) begin
			if (we) mem[k][tix] <= tval;
			if (en) rd[k] <= mem[k][ra[k]];
		end
	end

	// ports 0-1: X, X+1 (address at s1, data at s2)
	// ports 2-5: A, A+1, B, B+1 (address at s3, data at s4)
	// ports 6-13: eight corners (address at s5, data at s6)
	logic [TABLE_AW-1:0] a_s3, b_s3;
	logic [TABLE_AW-1:0] aa_s5, ab_s5, ba_s5, bb_s5;

	assign ra[0]  = TABLE_AW'(ix_s1);
	assign ra[1]  = TABLE_AW'(ix_s1) + 1'b1;
	assign ra[2]  = a_s3;
	assign ra[3]  = a_s3 + 1'b1;
	assign ra[4]  = b_s3;
	assign ra[5]  = b_s3 + 1'b1;
	assign ra[6]  = aa_s5;
	assign ra[7]  = ba_s5;
	assign ra[8]  = ab_s5;
	assign ra[9]  = bb_s5;
	assign ra[10] = aa_s5 + 1'b1;
	assign ra[11] = ba_s5 + 1'b1;
	assign ra[12] = ab_s5 + 1'b1;
	assign ra[13] = bb_s5 + 1'b1;

	// memory outputs land in stage 2/4/6; those of stage 2/4 give addresses in the next stage
	always_ff @(posedge clk) begin
		if (en) begin
			a_s3 <= TABLE_AW'(rd[0]) + TABLE_AW'(iy_s2);
			b_s3 <= TABLE_AW'(rd[1]) + TABLE_AW'(iy_s2);
			aa_s5 <= TABLE_AW'(rd[2]) + TABLE_AW'(iz_s4);
			ab_s5 <= TABLE_AW'(rd[3]) + TABLE_AW'(iz_s4);
			ba_s5 <= TABLE_AW'(rd[4]) + TABLE_AW'(iz_s4);
			bb_s5 <= TABLE_AW'(rd[5]) + TABLE_AW'(iz_s4);
		end
	end

	// ---- fade: inputs at s5 fraction, fade valid at s8 ----
	logic [FD_W-1:0] fu_s8, fv_s8, fw_s8;
	pn3d_fade u_fade_x (.clk, .en, .t(fx_s[5]), .fade(fu_s8));
	pn3d_fade u_fade_y (.clk, .en, .t(fy_s[5]), .fade(fv_s8));
	pn3d_fade u_fade_z (.clk, .en, .t(fz_s[5]), .fade(fw_s8));

	logic [FD_W-1:0] fv_s9, fw_s9, fw_s10;

	// ---- gradients at s7 (hash data sits in rd during s6) ----
	localparam int ONEI = 1 << FRAC_BITS;
	ofs_t x0, y0, z0, x1, y1, z1;
	grad_t g_s7 [8];
	grad_t g_s8 [8];

	assign x0 = ofs_t'({2'b00, fx_s[6]});
	assign y0 = ofs_t'({2'b00, fy_s[6]});
	assign z0 = ofs_t'({2'b00, fz_s[6]});
	assign x1 = x0 - ofs_t'(ONEI);
	assign y1 = y0 - ofs_t'(ONEI);
	assign z1 = z0 - ofs_t'(ONEI);

	always_ff @(posedge clk) begin
		if (en) begin
			g_s7[0] <= grad_sel(rd[6][3:0], x0, y0, z0);
			g_s7[1] <= grad_sel(rd[7][3:0], x1, y0, z0);
			g_s7[2] <= grad_sel(rd[8][3:0], x0, y1, z0);
			g_s7[3] <= grad_sel(rd[9][3:0], x1, y1, z0);
			g_s7[4] <= grad_sel(rd[10][3:0], x0, y0, z1);
			g_s7[5] <= grad_sel(rd[11][3:0], x1, y0, z1);
			g_s7[6] <= grad_sel(rd[12][3:0], x0, y1, z1);
			g_s7[7] <= grad_sel(rd[13][3:0], x1, y1, z1);
			g_s8    <= g_s7;
			fv_s9   <= fv_s8;
			fw_s9   <= fw_s8;
			fw_s10  <= fw_s9;
		end
	end

	// lerp: a + floor(t*(b-a) >> F); one multiply per lerp
	function automatic lval_t lerp(input logic [FD_W-1:0] t, input lval_t a, input lval_t b);
		logic signed [LP_W+1:0]      d;
		logic signed [LP_W+FD_W+2:0] p;
		d = (LP_W+2)'(b) - (LP_W+2)'(a);
		p = $signed({1'b0, t}) * d;
		return a + lval_t'(p >>> FRAC_BITS);
	endfunction

	lval_t l1_s9 [4];
	lval_t l2_s10 [2];
	lval_t l3_s11;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++)
				l1_s9[k] <= lerp(fu_s8, lval_t'(g_s8[2*k]), lval_t'(g_s8[2*k+1]));
			l2_s10[0] <= lerp(fv_s9, l1_s9[0], l1_s9[1]);
			l2_s10[1] <= lerp(fv_s9, l1_s9[2], l1_s9[3]);
			l3_s11    <= lerp(fw_s10, l2_s10[0], l2_s10[1]);
		end
	end

	// ---- scale, saturate, output register (stage 12) ----
	localparam int SC_W = LP_W + 8;
	localparam lval_t OMAX = lval_t'((1 << (OUT_W - 1)) - 1);
	localparam lval_t OMIN = lval_t'(-(1 << (OUT_W - 1)));
	logic signed [SC_W-1:0] scaled;
	logic signed [OUT_W-1:0] sat;

	always_comb begin
		if (FRAC_BITS > OUT_FRAC)
			scaled = SC_W'(l3_s11) >>> (FRAC_BITS - OUT_FRAC);
		else
			scaled = SC_W'(l3_s11) <<< (OUT_FRAC - FRAC_BITS);
		if (scaled > SC_W'(OMAX))
			sat = OUT_W'(OMAX);
		else if (scaled < SC_W'(OMIN))
			sat = OUT_W'(OMIN);
		else
			sat = OUT_W'(scaled);
	end

	logic [OUT_W-1:0] noise_q;
	always_ff @(posedge clk) begin
		if (en)
			noise_q <= ld[NST-1] ? '0 : sat;
	end

	assign m_tdata = OUT_TDATA_W'(noise_q);
	assign m_tuser = ld[NST];

	// ---- assertions ----
	a_load_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> noise_q == '0)
		else $error("load transaction returned nonzero noise");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(noise_q))
		else $error("stalled result changed");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid && !load_hold |-> s_tready)
		else $error("input blocked with empty output");
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && m_tready |=> vld[1])
		else $error("accepted transaction lost at pipe entry");
endmodule

// ----- rtl/pn3d_fade.sv -----
// ---------------------------------------------------------------------------
// pn3d_fade
// Fade curve 6t^5-15t^4+10t^3 in Q0.F, truncating; three register stages.
// ---------------------------------------------------------------------------
module pn3d_fade import pn3d_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [FR_W-1:0]  t,
	output logic [FD_W-1:0]  fade
);
	localparam int ONE = 1 << FRAC_BITS;

	logic [FR_W-1:0]     t_s1;
	logic [FR_W-1:0]     t2_s1;
	logic [FR_W-1:0]     t3_s2;
	logic [FR_W+4:0]     poly_s2;
	logic [2*FR_W-1:0]   t_sq;
	logic [2*FR_W-1:0]   t_cu;
	logic signed [FR_W+6:0] poly_c;
	logic [2*FR_W+4:0]   prod;

	assign t_sq = t * t;
	assign t_cu = t2_s1 * t_s1;
	// 10*one - 15t + 6t2 is always positive for t < one
	assign poly_c = (FR_W+7)'(10 * ONE) - (FR_W+7)'(15) * $signed({7'd0, t_s1})
		+ (FR_W+7)'(6) * $signed({7'd0, t2_s1});
	assign prod = t3_s2 * poly_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1    <= t;
			t2_s1   <= t_sq[2*FR_W-1:FR_W];
			t3_s2   <= t_cu[2*FR_W-1:FR_W];
			poly_s2 <= (FR_W+5)'(poly_c);
			fade    <= (prod[2*FR_W+4:FR_W] > (FR_W+5)'(ONE)) ? FD_W'(ONE)
				: prod[FR_W+FD_W-1:FR_W];
		end
	end
endmodule
